[sv/smas_pkg.sv]
// ----------------------------------------------------------------------------
// smas_pkg
// Shared constants for the stroke moving-average smoother: register map,
// register widths and reset values, and parameter defaults.
// ----------------------------------------------------------------------------
package smas_pkg;

    // parameter defaults
    localparam int DEF_MAX_HALF_WINDOW = 8;
    localparam int DEF_COORD_BITS      = 16;

    // configuration port
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // register indexes (word address = paddr[2])
    localparam logic REG_HALF_WINDOW = 1'b0;

    // half_window register
    localparam int               HALF_W_W   = 4;
    localparam logic [HALF_W_W-1:0] HALF_W_RST = 4'd2;

    // saturating count of points in the current stroke
    localparam int SEEN_W = 16;

endpackage

[sv/smas_div.sv]
// ----------------------------------------------------------------------------
// smas_div
// Sequential signed-by-unsigned divider, one quotient bit per cycle.
// Quotient truncates toward zero; held stable after done until next start.
// ----------------------------------------------------------------------------
module smas_div #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    input  logic        [DIVISOR_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic signed [DIVIDEND_W-1:0] o_quot
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic                  r_neg;

    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    // one restoring step
    assign shifted = {r_rem, r_q[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: magnitude shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIVIDEND_W-1];
            r_q   <= i_dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-i_dividend)
                                              : DIVIDEND_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DIVISOR_W'(shifted - {1'b0, r_dvs}) : DIVISOR_W'(shifted);
            r_q   <= {r_q[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

[sv/stroke_moving_average_smoother_core.sv]
// ----------------------------------------------------------------------------
// stroke_moving_average_smoother_core
// Centered moving average over 2k+1 points of a pen stroke, edges replicated.
// Point history lives in a ring memory; sums are read back point by point
// and divided by 2k+1 in bit-serial dividers, one per coordinate.
//
//  channel   dir  handshake                 payload
//  s_*       in   i_s_tvalid / o_s_tready   tdata {y, x}, tlast = end_of_stroke
//  m_*       out  o_m_tvalid / i_m_tready   tdata {y, x}, tlast = stroke_done
//  apb       in   psel & penable, pready=1  reg 0 half_window (4 bits)
//
// A point that completes no window leaves o_s_tready high. Each smoothed
// point takes ring reads over its window (one memory read per cycle), one
// divider start, a wait on the divider and an output load, all after the
// accept. An end-of-stroke beat flushes up to k+1 points one after another.
// o_s_tready is low while points are being computed; a full output register
// stalls only the final load.
// Reset is synchronous; it clears control state and sets half_window to 2.
// ----------------------------------------------------------------------------
module stroke_moving_average_smoother_core
    import smas_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
    parameter int COORD_BITS      = DEF_COORD_BITS,
    localparam int TDATA_W        = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input stream
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // in_x, in_y, zero pad
    input  logic               i_s_tlast,
    // output stream
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // out_x, out_y, zero pad
    output logic               o_m_tlast,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int CW    = COORD_BITS;
    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int HW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_HALF_WINDOW + 1);
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int AW    = CNTW + 2;
    localparam int SW    = CW + $clog2(DEPTH);
    localparam int DVW   = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_DIVS = 3'd2;
    localparam logic [2:0] S_DIVW = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // registers
    logic [HALF_W_W-1:0] r_hw;
    logic [2:0]          r_state, n_state;
    logic [HW-1:0]       r_head, n_head;
    logic [SEEN_W-1:0]   r_seen, n_seen;
    logic [SEEN_W-1:0]   r_m, n_m;
    logic [KW-1:0]       r_k, n_k;
    logic [KW-1:0]       r_d, n_d;
    logic                r_last, n_last;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic signed [SW-1:0] r_sx, n_sx;
    logic signed [SW-1:0] r_sy, n_sy;
    logic                r_ovld, n_ovld;
    logic [CW-1:0]       r_ox, n_ox;
    logic [CW-1:0]       r_oy, n_oy;
    logic                r_olast, n_olast;

    // history ring
    logic [2*CW-1:0]     mem [DEPTH];
    logic [2*CW-1:0]     r_rd;
    logic [HW-1:0]       rd_addr;
    logic [HW-1:0]       head_inc;
    logic                in_beat;

    // window arithmetic
    logic [KW-1:0]        k_cfg;
    logic [SEEN_W-1:0]    seen_inc;
    logic [SEEN_W-1:0]    m_new;
    logic signed [AW-1:0] age_s;
    logic [AW-1:0]        age_u;
    logic [HW-1:0]        age_c;
    logic [HW:0]          addr_wrap;

    // divider
    logic                 div_start;
    logic                 done_x, done_y;
    logic signed [SW-1:0] q_x, q_y;
    logic [DVW-1:0]       divisor;

    // ------------------------------------------------------------------
    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw <= HALF_W_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_HALF_WINDOW) begin
            r_hw <= pwdata[HALF_W_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HALF_WINDOW) ? APB_DW'(r_hw) : '0;

    // clamp k to the ring size
    assign k_cfg = (int'(r_hw) > MAX_HALF_WINDOW) ? KW'(MAX_HALF_WINDOW) : KW'(r_hw);

    // ------------------------------------------------------------------
    // ring write / read
    assign in_beat  = i_s_tvalid && o_s_tready;
    assign head_inc = (r_head == HW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // age of the point read this cycle: d + k - j, clamped to [0, m]
    assign age_s = AW'(r_d) + AW'(r_k) - AW'(r_cnt);
    assign age_u = age_s;
    always_comb begin
        if (age_s < 0) begin
            age_c = '0;
        end else if (SEEN_W'(age_u) > r_m) begin
            age_c = HW'(r_m);
        end else begin
            age_c = HW'(age_u);
        end
    end
    assign addr_wrap = {1'b0, r_head} + (HW + 1)'(DEPTH) - {1'b0, age_c};
    assign rd_addr   = (r_head >= age_c) ? r_head - age_c : HW'(addr_wrap);

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            mem[head_inc] <= {i_s_tdata[2*CW-1:CW], i_s_tdata[CW-1:0]};
        end
        r_rd <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // sequencer
    assign seen_inc = (&r_seen) ? r_seen : r_seen + 1'b1;
    assign m_new    = seen_inc - 1'b1;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_seen  = r_seen;
        n_m     = r_m;
        n_k     = r_k;
        n_d     = r_d;
        n_last  = r_last;
        n_cnt   = r_cnt;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_ovld  = r_ovld;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_olast = r_olast;

        if (o_m_tvalid && i_m_tready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_head = head_inc;
                    n_k    = k_cfg;
                    n_last = i_s_tlast;
                    n_m    = m_new;
                    n_seen = i_s_tlast ? '0 : seen_inc;
                    n_cnt  = '0;
                    n_sx   = '0;
                    n_sy   = '0;
                    if (i_s_tlast) begin
                        n_d     = (m_new < SEEN_W'(k_cfg)) ? KW'(m_new) : k_cfg;
                        n_state = S_ACC;
                    end else if (m_new >= SEEN_W'(k_cfg)) begin
                        n_d     = k_cfg;
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: begin
                // read issued at cnt, data summed in the following cycle
                n_cnt = r_cnt + 1'b1;
                if (r_cnt != '0) begin
                    n_sx = r_sx + SW'($signed(r_rd[CW-1:0]));
                    n_sy = r_sy + SW'($signed(r_rd[2*CW-1:CW]));
                end
                if (r_cnt == CNTW'({r_k, 1'b1})) begin
                    n_state = S_DIVS;
                end
            end
            S_DIVS: begin
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (done_x && done_y) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovld || i_m_tready) begin
                    n_ovld  = 1'b1;
                    n_ox    = q_x[CW-1:0];
                    n_oy    = q_y[CW-1:0];
                    n_olast = r_last && (r_d == '0);
                    if (r_last && r_d != '0) begin
                        n_d     = r_d - 1'b1;
                        n_cnt   = '0;
                        n_sx    = '0;
                        n_sy    = '0;
                        n_state = S_ACC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_seen  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_seen  <= n_seen;
            r_ovld  <= n_ovld;
        end
    end

    // payload and per-item work registers
    always_ff @(posedge i_clk) begin
        r_m     <= n_m;
        r_k     <= n_k;
        r_d     <= n_d;
        r_last  <= n_last;
        r_cnt   <= n_cnt;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_olast <= n_olast;
    end

    // ------------------------------------------------------------------
    // divide by window length
    assign div_start = (r_state == S_DIVS);
    assign divisor   = DVW'({r_k, 1'b1});

    smas_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (DVW)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sx),
        .i_divisor  (divisor),
        .o_done     (done_x),
        .o_quot     (q_x)
    );

    smas_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (DVW)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sy),
        .i_divisor  (divisor),
        .o_done     (done_y),
        .o_quot     (q_y)
    );

    // ------------------------------------------------------------------
    // ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = TDATA_W'({r_oy, r_ox});
    assign o_m_tlast  = r_olast;

endmodule

[sv/smas_chk.sv]
// ----------------------------------------------------------------------------
// smas_chk
// Port-level checks for the stroke smoother, bound to the top level.
// ----------------------------------------------------------------------------
module smas_chk #(
    parameter int TdataW = 32
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic              i_s_tlast,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [TdataW-1:0] o_m_tdata,
    input logic              o_m_tlast,
    input logic              pready
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    // end of stroke always starts a flush, so input closes next cycle
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("no flush after end of stroke");

    // input closes only after an accepted beat
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(i_s_tvalid))
        else $error("tready dropped without an input beat");

endmodule

bind stroke_moving_average_smoother_core smas_chk #(
    .TdataW (TDATA_W)
) u_smas_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .pready     (pready)
);

[bench/stroke_smoother_checker.sv]
// ----------------------------------------------------------------------------
// stroke_smoother_checker
// Watches the point stream, the smoothed-point stream and the register port
// of the stroke smoother. It keeps its own copy of the stroke history and the
// half-window setting, works out the smoothed points that each accepted input
// beat causes, and compares every output beat against the oldest one waiting.
// ----------------------------------------------------------------------------
module stroke_smoother_checker
    import smas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [31:0]       i_s_tdata,   // in_x, in_y
    input  logic              i_s_tlast,
    // output stream
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [31:0]       i_m_tdata,   // out_x, out_y
    input  logic              i_m_tlast,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    // status to the bench top
    output int                o_errors,
    output int                o_pending
);

    localparam int CW       = DEF_COORD_BITS;
    localparam int MAX_HW   = DEF_MAX_HALF_WINDOW;
    localparam int HIST_N   = 2 * MAX_HW + 1;
    localparam int SEEN_MAX = (1 << SEEN_W) - 1;
    localparam int REPORT_N = 10;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 done;
    } t_smooth_pt;

    // shadow of the block state
    logic signed [CW-1:0] trace_x [HIST_N];
    logic signed [CW-1:0] trace_y [HIST_N];
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic [HALF_W_W-1:0]  half_win;
    int                   wr_pos;
    int                   stroke_len;

    t_smooth_pt smoothed_q [$];
    int         mismatch_count = 0;

    assign o_errors = mismatch_count;

    // Take one point into the history and queue the smoothed points it releases.
    task automatic smooth_point(input logic signed [CW-1:0] px,
                                input logic signed [CW-1:0] py,
                                input logic                 last);
        int         k;
        int         m;
        int         d;
        int         j;
        int         age;
        int         pos;
        int         sx;
        int         sy;
        t_smooth_pt pt;
        k = (half_win > MAX_HW) ? MAX_HW : int'(half_win);
        if (stroke_len == 0) begin
            start_x = px;
            start_y = py;
        end
        wr_pos          = (wr_pos + 1) % HIST_N;
        trace_x[wr_pos] = px;
        trace_y[wr_pos] = py;
        if (stroke_len < SEEN_MAX)
            stroke_len++;
        m = stroke_len - 1;
        if (!last && m < k)
            return;
        // mid-stroke only the point k behind is ready; at the end all pending ones
        d = (last && m < k) ? m : k;
        while (d >= 0) begin
            sx = 0;
            sy = 0;
            for (j = -k; j <= k; j++) begin
                age = d - j;
                if (age < 0) begin
                    sx += trace_x[wr_pos];
                    sy += trace_y[wr_pos];
                end else if (age > m) begin
                    sx += start_x;
                    sy += start_y;
                end else begin
                    pos = (wr_pos + HIST_N - age) % HIST_N;
                    sx += trace_x[pos];
                    sy += trace_y[pos];
                end
            end
            // int division truncates toward zero
            pt.x    = CW'(sx / (2 * k + 1));
            pt.y    = CW'(sy / (2 * k + 1));
            pt.done = last && (d == 0);
            smoothed_q.insert(smoothed_q.size(), pt);
            if (!last)
                break;
            d--;
        end
        if (last)
            stroke_len = 0;
    endtask

    // Compare one output beat with the oldest expected point.
    task automatic check_output(input logic signed [CW-1:0] gx,
                                input logic signed [CW-1:0] gy,
                                input logic                 gdone);
        t_smooth_pt want;
        if (smoothed_q.size() == 0) begin
            if (mismatch_count < REPORT_N)
                $display("output beat with nothing expected: x=%0d y=%0d done=%0b",
                         gx, gy, gdone);
            mismatch_count++;
        end else begin
            want = smoothed_q.pop_front();
            if (want.x !== gx || want.y !== gy || want.done !== gdone) begin
                if (mismatch_count < REPORT_N)
                    $display("smoothed point mismatch: expected x=%0d y=%0d done=%0b,",
                             want.x, want.y, want.done,
                             " got x=%0d y=%0d done=%0b", gx, gy, gdone);
                mismatch_count++;
            end
        end
    endtask

    // Sample all channels at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            half_win   = HALF_W_RST;
            wr_pos     = 0;
            stroke_len = 0;
            smoothed_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_HALF_WINDOW)
                half_win = pwdata[HALF_W_W-1:0];
            if (i_s_tvalid && i_s_tready)
                smooth_point(i_s_tdata[CW-1:0], i_s_tdata[2*CW-1:CW], i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_output(i_m_tdata[CW-1:0], i_m_tdata[2*CW-1:CW], i_m_tlast);
        end
        o_pending = smoothed_q.size();
    end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the stroke moving-average smoother. A directed
// part covers coordinate extremes, short strokes, the window clamp and a
// window change inside a stroke; random phases follow with random strokes,
// half-window settings and idle bursts on both streams, plus one long
// receiver hold-off. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module testbench;
    import smas_pkg::*;

    localparam int CW              = DEF_COORD_BITS;
    localparam int TD_W            = ((2 * CW + 7) / 8) * 8;
    localparam int RANDOM_POINTS   = 70;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PRESSURE_PHASE  = 2;

    localparam logic signed [CW-1:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [CW-1:0] COORD_MIN = 16'sh8000;

    typedef enum int {SHAPE_NOISE, SHAPE_WALK, SHAPE_CORNERS} t_shape;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input stream
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [TD_W-1:0] s_tdata  = '0;   // in_x, in_y
    logic            s_tlast  = 1'b0;
    // output stream
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [TD_W-1:0] m_tdata;         // out_x, out_y
    logic            m_tlast;
    // register port
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int err_count;
    int exp_pending;

    bit idle_en  = 1'b0;
    bit hold_req = 1'b0;

    int points_sent  = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int long_holds   = 0;
    int quiet_cycles = 0;

    // random stroke generator state
    int                   stroke_left = 0;
    t_shape               shape       = SHAPE_NOISE;
    logic signed [CW-1:0] walk_x      = '0;
    logic signed [CW-1:0] walk_y      = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    stroke_moving_average_smoother_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    stroke_smoother_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tlast  (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .o_errors   (err_count),
        .o_pending  (exp_pending)
    );

    // Watchdog: end the run when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                     (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
                long_holds++;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_half(input logic [HALF_W_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_HALF_WINDOW, 2'b00};
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one point beat, with an optional idle burst ahead of it.
    task automatic send_point(input logic signed [CW-1:0] px,
                              input logic signed [CW-1:0] py,
                              input logic                 last);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        points_sent++;
        @(negedge i_clk);
    endtask

    // Wait out every expected point, then let the block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (exp_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Half-window choice: extremes and clamped values now and then.
    function automatic logic [HALF_W_W-1:0] pick_half();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return HALF_W_W'(DEF_MAX_HALF_WINDOW);
            2:       return '1;
            3:       return HALF_W_W'($urandom_range(DEF_MAX_HALF_WINDOW + 1, 15));
            default: return HALF_W_W'($urandom_range(0, DEF_MAX_HALF_WINDOW));
        endcase
    endfunction

    function automatic logic signed [CW-1:0] next_coord(input logic signed [CW-1:0] prev,
                                                        input t_shape            kind);
        case (kind)
            SHAPE_NOISE: return CW'($urandom);
            SHAPE_WALK:  return prev + CW'($urandom_range(0, 64)) - CW'(32);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return CW'($urandom_range(0, 3)) - CW'(2);
                    default: return CW'($urandom);
                endcase
            end
        endcase
    endfunction

    // Next point of the current random stroke; starts a new stroke as needed.
    task automatic send_stroke_point();
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        if (stroke_left == 0) begin
            case ($urandom_range(0, 3))
                0:       stroke_left = $urandom_range(1, 3);
                1, 2:    stroke_left = $urandom_range(4, 12);
                default: stroke_left = $urandom_range(13, 30);
            endcase
            shape  = t_shape'($urandom_range(0, 2));
            walk_x = CW'($urandom);
            walk_y = CW'($urandom);
        end
        nx     = next_coord(walk_x, shape);
        ny     = next_coord(walk_y, shape);
        walk_x = nx;
        walk_y = ny;
        stroke_left--;
        send_point(nx, ny, stroke_left == 0);
    endtask

    // Main sequence.
    initial begin
        int i;
        int phase;
        int budget;
        int directed_pts;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes under the reset half window
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(-16'sd1, 16'sd1, 1'b1);
        // stroke of a single point
        send_point(COORD_MIN, COORD_MAX, 1'b1);

        // no context at all
        settle();
        write_half('0);
        send_point(16'sd5, -16'sd7, 1'b0);
        send_point(COORD_MIN, -16'sd1, 1'b1);

        // too large a window is clamped; stroke shorter than the window
        settle();
        write_half('1);
        send_point(COORD_MAX, 16'sd0, 1'b0);
        send_point(-16'sd3, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);

        // widest window, stroke just long enough, full flush at the end
        settle();
        write_half(HALF_W_W'(DEF_MAX_HALF_WINDOW));
        for (i = 0; i <= DEF_MAX_HALF_WINDOW; i++)
            send_point(i[0] ? COORD_MIN : COORD_MAX, CW'(i * 1000 - 4000),
                       i == DEF_MAX_HALF_WINDOW);

        // window changed in the middle of a stroke
        settle();
        write_half(HALF_W_W'(3));
        for (i = 0; i < 4; i++)
            send_point(CW'(i * 77 - 100), CW'(-i * 311), 1'b0);
        settle();
        write_half(HALF_W_W'(1));
        send_point(16'sd900, -16'sd900, 1'b1);
        directed_pts = points_sent;

        // random phases; a phase may stop in the middle of a stroke
        phase = 0;
        while (points_sent < directed_pts + RANDOM_POINTS) begin
            settle();
            if (phase == PRESSURE_PHASE) begin
                write_half(HALF_W_W'(1));
                idle_en  = 1'b0;
                hold_req = 1'b1;
                budget   = 24;
            end else begin
                write_half(pick_half());
                idle_en = ($urandom_range(0, 3) != 0);
                budget  = $urandom_range(8, 24);
            end
            repeat (budget) send_stroke_point();
            phase++;
        end

        // closing stretch without idling; finish the open stroke
        settle();
        write_half(pick_half());
        idle_en = 1'b0;
        repeat (16) send_stroke_point();
        while (stroke_left != 0) send_stroke_point();
        s_tvalid <= 1'b0;
        while (exp_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("run: %0d points in, %0d smoothed points out,", points_sent, results_seen,
                 " %0d window writes, %0d long holds", cfg_writes, long_holds);
        $display("run: extremes, short and clamped strokes, mid-stroke window change, stalls");
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
